/* rtl/core/nhtlp_pkg.sv */
// ----------------------------------------------------------------------------
// nhtlp_pkg
// shared types and codes for the linear-probe name hash table
// ----------------------------------------------------------------------------
package nhtlp_pkg;

   localparam int NAME_W  = 64;
   localparam int VALUE_W = 32;
   localparam int SIZE_W  = 9;

   typedef enum logic [1:0] {
      ACT_INSERT     = 2'd0,
      ACT_FIND_NAME  = 2'd1,
      ACT_FIND_VALUE = 2'd2,
      ACT_CLEAR      = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // zero every byte from the first nul onwards
   function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] n);
      logic [NAME_W-1:0] r;
      logic              stop;
      r    = '0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (n[8*i +: 8] == 8'd0) stop = 1'b1;
         if (!stop) r[8*i +: 8] = n[8*i +: 8];
      end
      return r;
   endfunction

endpackage

/* rtl/core/nhtlp_ram.sv */
// ----------------------------------------------------------------------------
// nhtlp_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module nhtlp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

/* rtl/core/nhtlp_mod.sv */
// ----------------------------------------------------------------------------
// nhtlp_mod
// serial remainder of a 32-bit sum by the table size, one bit a cycle
// ----------------------------------------------------------------------------
module nhtlp_mod
   import nhtlp_pkg::*;
#(
   parameter int IDX_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [31:0]       dividend,
   input  logic [IDX_W:0]    divisor,
   output logic              done,
   output logic [IDX_W-1:0]  remainder
);
   logic [31:0]      num_ff, num_in;
   logic [IDX_W+1:0] rem_ff, rem_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [IDX_W+1:0] trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[IDX_W:0], num_ff[31]};
      if (go) begin
         num_in = dividend;
         rem_in = '0;
         cnt_in = 6'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // restoring step, remainder stays below the divisor
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         num_in = {num_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[IDX_W-1:0];
endmodule

/* rtl/core/name_hash_table_linear_probe.sv */
// ----------------------------------------------------------------------------
// name_hash_table_linear_probe
// open addressing hash table of short names with linear probing
// ----------------------------------------------------------------------------
// steps: hash one byte at a time up to the first nul or the eighth byte, then
//   the serial remainder, then a read and a check per probed slot; find by value
//   reads and checks each scanned slot; clear writes all slots; then the result
// throughput: one item at a time, busy stays high through the result strobe
// reset: synchronous, clears the control state, sets table_size to 256 and
//   runs a clearing pass over every slot with busy high
// the receiver cannot stall: each result is shown for one cycle only
module name_hash_table_linear_probe
   import nhtlp_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_action,
   input  logic [NAME_W-1:0]    req_key_name,
   input  logic [VALUE_W-1:0]   req_key_value,
   input  logic                 csr_wr_en,
   input  logic [SIZE_W-1:0]    csr_table_size,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [VALUE_W-1:0]   rsp_found_value,
   output logic [NAME_W-1:0]    rsp_found_name,
   output logic [7:0]           rsp_slot_index
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int SZ_W  = IDX_W + 1;

   // one-hot sequencer
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_HASH  = 8'b0000_0010,
      S_MOD   = 8'b0000_0100,
      S_READ  = 8'b0000_1000,
      S_CHECK = 8'b0001_0000,
      S_CLEAR = 8'b0010_0000,
      S_DONE  = 8'b0100_0000,
      S_WAIT  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   action_type        act_ff, act_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [31:0]       sum_ff, sum_in;
   logic [4:0]        sh_ff, sh_in;
   logic [3:0]        byte_ff, byte_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [IDX_W-1:0]  home_ff, home_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        st_ff, st_in;
   logic [VALUE_W-1:0] fval_ff, fval_in;
   logic [NAME_W-1:0] fname_ff, fname_in;
   logic [7:0]        idx_ff, idx_in;
   logic              rsp_ff, rsp_in;

   logic [SZ_W-1:0]   used;
   logic              mod_go, mod_done;
   logic [IDX_W-1:0]  mod_rem;
   logic              wr_en;
   logic [IDX_W-1:0]  ram_addr;
   logic [NAME_W-1:0] wr_name, rd_name;
   logic [VALUE_W-1:0] wr_val, rd_val;
   logic [IDX_W-1:0]  slot_next;
   logic [7:0]        cur_byte;

   // effective table size: zero reads as one, clamped to depth
   always_comb begin
      if (size_ff == '0) used = SZ_W'(1);
      else if ({{(32-SIZE_W){1'b0}}, size_ff} > 32'(TABLE_DEPTH)) used = SZ_W'(TABLE_DEPTH);
      else used = SZ_W'(size_ff);
   end

   nhtlp_mod #(.IDX_W(IDX_W)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .go       (mod_go),
      .dividend (sum_ff),
      .divisor  (used),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   nhtlp_ram #(.WIDTH(NAME_W), .DEPTH(TABLE_DEPTH)) u_names (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr), .wr_data(wr_name), .rd_data(rd_name)
   );
   nhtlp_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_values (
      .clock(clock), .wr_en(wr_en), .addr(ram_addr), .wr_data(wr_val), .rd_data(rd_val)
   );

   // linear probe step with wrap at the used size
   assign slot_next = ({1'b0, slot_ff} + SZ_W'(1) >= used) ? '0 : slot_ff + IDX_W'(1);
   assign cur_byte  = name_ff[8*byte_ff[2:0] +: 8];
   assign ram_addr  = (state_ff == S_CLEAR) ? cnt_ff : slot_ff;

   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      act_in   = act_ff;
      name_in  = name_ff;
      val_in   = val_ff;
      sum_in   = sum_ff;
      sh_in    = sh_ff;
      byte_in  = byte_ff;
      slot_in  = slot_ff;
      home_in  = home_ff;
      cnt_in   = cnt_ff;
      st_in    = st_ff;
      fval_in  = fval_ff;
      fname_in = fname_ff;
      idx_in   = idx_ff;
      rsp_in   = 1'b0;
      mod_go   = 1'b0;
      wr_en    = 1'b0;
      wr_name  = name_ff;
      wr_val   = val_ff;
      if (csr_wr_en) size_in = csr_table_size;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in   = action_type'(req_action);
               name_in  = clean_name(req_key_name);
               val_in   = req_key_value;
               sum_in   = '0;
               sh_in    = '0;
               byte_in  = '0;
               slot_in  = '0;
               cnt_in   = '0;
               st_in    = ST_OK;
               fval_in  = '0;
               fname_in = '0;
               idx_in   = '0;
               case (action_type'(req_action))
                  ACT_INSERT: begin
                     state_in = (req_key_value == '0) ? S_DONE : S_HASH;
                  end
                  ACT_FIND_NAME: begin
                     st_in    = ST_NOT_FOUND;
                     state_in = S_HASH;
                  end
                  ACT_FIND_VALUE: begin
                     st_in    = ST_NOT_FOUND;
                     state_in = (req_key_value == '0) ? S_DONE : S_READ;
                  end
                  default: state_in = S_CLEAR;
               endcase
            end
         end
         S_HASH: begin
            // one byte a cycle; a cleaned name is zero from the first nul
            if (byte_ff == 4'd8 || cur_byte == 8'd0) begin
               state_in = S_MOD;
               mod_go   = 1'b1;
            end else begin
               sum_in  = sum_ff + ({24'd0, cur_byte} << sh_ff);
               sh_in   = sh_ff + 5'd7;
               byte_in = byte_ff + 4'd1;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               slot_in  = mod_rem;
               home_in  = mod_rem;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (act_ff == ACT_FIND_VALUE) begin
               if (rd_val == val_ff) begin
                  st_in    = ST_OK;
                  fname_in = rd_name;
                  idx_in   = 8'(slot_ff);
                  state_in = S_DONE;
               end else if ({1'b0, slot_ff} + SZ_W'(1) >= used) begin
                  state_in = S_DONE;
               end else begin
                  slot_in  = slot_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end else if (rd_val == '0) begin
               if (act_ff == ACT_INSERT) begin
                  wr_en  = 1'b1;
                  idx_in = 8'(slot_ff);
               end
               state_in = S_DONE;
            end else if (rd_name == name_ff) begin
               idx_in = 8'(slot_ff);
               if (act_ff == ACT_INSERT) st_in = ST_DUPLICATE;
               else begin
                  st_in   = ST_OK;
                  fval_in = rd_val;
               end
               state_in = S_DONE;
            end else if (slot_next == home_ff) begin
               if (act_ff == ACT_INSERT) st_in = ST_FULL;
               state_in = S_DONE;
            end else begin
               slot_in  = slot_next;
               state_in = S_READ;
            end
         end
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_name = '0;
            wr_val  = '0;
            cnt_in  = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(TABLE_DEPTH - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            rsp_in   = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         size_ff  <= SIZE_W'(256);
         cnt_ff   <= '0;
         rsp_ff   <= 1'b0;
         act_ff   <= ACT_CLEAR;
      end else begin
         // the reset clearing pass ends in a silent return to idle
         state_ff <= (state_ff == S_CLEAR && state_in == S_DONE && act_ff == ACT_CLEAR
                      && !rsp_ff && st_ff == ST_FULL) ? S_IDLE : state_in;
         size_ff  <= size_in;
         cnt_ff   <= cnt_in;
         rsp_ff   <= rsp_in;
         act_ff   <= (state_ff == S_CLEAR && state_in == S_DONE && st_ff == ST_FULL)
                     ? ACT_INSERT : act_in;
      end
      name_ff  <= name_in;
      val_ff   <= val_in;
      sum_ff   <= sum_in;
      sh_ff    <= sh_in;
      byte_ff  <= byte_in;
      slot_ff  <= slot_in;
      home_ff  <= home_in;
      fval_ff  <= fval_in;
      fname_ff <= fname_in;
      idx_ff   <= idx_in;
      // marks the reset pass so it ends without a result
      st_ff    <= reset ? ST_FULL : st_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_ff;
   assign rsp_status      = st_ff;
   assign rsp_found_value = fval_ff;
   assign rsp_found_name  = fname_ff;
   assign rsp_slot_index  = idx_ff;
endmodule

/* bench/tb_name_hash_table_linear_probe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_name_hash_table_linear_probe
// self-checking bench for the linear-probe name hash table: a queue-fed
// driver sends insert, lookup and clear items in bursts, an internal table
// model predicts each response and a monitor compares every field
// ----------------------------------------------------------------------------
module tb_name_hash_table_linear_probe;
   import nhtlp_pkg::*;

   localparam int DEPTH      = 256;
   localparam int IDLE_LIMIT = 5000;

   typedef struct packed {
      action_type        act;
      logic [NAME_W-1:0] name;
      logic [VALUE_W-1:0] val;
   } table_op_t;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] fval;
      logic [NAME_W-1:0]  fname;
      logic [7:0]         slot;
   } table_resp_t;

   logic clock, reset, start, busy, csr_wr_en, rsp_valid;
   logic [1:0]          req_action, rsp_status;
   logic [NAME_W-1:0]   req_key_name, rsp_found_name;
   logic [VALUE_W-1:0]  req_key_value, rsp_found_value;
   logic [SIZE_W-1:0]   csr_table_size;
   logic [7:0]          rsp_slot_index;

   name_hash_table_linear_probe #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

   // predictor state: mirror of the table contents and the size register
   logic [NAME_W-1:0]  mdl_names [DEPTH];
   logic [VALUE_W-1:0] mdl_values [DEPTH];
   logic [SIZE_W-1:0]  mdl_size;

   table_op_t   pending_ops[$];
   table_resp_t expected_resps[$];
   int          mismatches, sent_count, idle_cycles;
   bit          timed_out;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // bytes after the first nul are dropped
   function automatic logic [NAME_W-1:0] trim_name(logic [NAME_W-1:0] n);
      logic [NAME_W-1:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (n[8*i +: 8] == 8'd0) break;
         r[8*i +: 8] = n[8*i +: 8];
      end
      return r;
   endfunction

   function automatic int bucket_of(logic [NAME_W-1:0] n, int size);
      logic [31:0] sum;
      int          sh;
      sum = '0;
      sh  = 0;
      for (int i = 0; i < 8; i++) begin
         if (n[8*i +: 8] == 8'd0) break;
         sum = sum + (32'(n[8*i +: 8]) << sh);
         sh  = (sh + 7) & 32'h1F;
      end
      return int'(sum % 32'(size));
   endfunction

   function automatic table_resp_t apply_table_op(table_op_t op);
      table_resp_t r;
      logic [NAME_W-1:0] nm;
      int size, slot, first;
      bit stop;
      r = '{ST_OK, '0, '0, '0};
      nm = trim_name(op.name);
      size = (mdl_size == 0) ? 1 : (mdl_size > DEPTH ? DEPTH : int'(mdl_size));
      case (op.act)
         ACT_INSERT: begin
            if (op.val != 0) begin
               slot = bucket_of(nm, size);
               first = slot;
               stop = 0;
               while (!stop && mdl_values[slot] != 0) begin
                  if (mdl_names[slot] == nm) begin
                     r.status = ST_DUPLICATE;
                     r.slot = 8'(slot);
                     stop = 1;
                  end else begin
                     slot = (slot + 1 >= size) ? 0 : slot + 1;
                     if (slot == first) begin
                        r.status = ST_FULL;
                        stop = 1;
                     end
                  end
               end
               if (!stop) begin
                  mdl_names[slot] = nm;
                  mdl_values[slot] = op.val;
                  r.slot = 8'(slot);
               end
            end
         end
         ACT_FIND_NAME: begin
            slot = bucket_of(nm, size);
            first = slot;
            r.status = ST_NOT_FOUND;
            while (mdl_values[slot] != 0) begin
               if (mdl_names[slot] == nm) begin
                  r.status = ST_OK;
                  r.fval = mdl_values[slot];
                  r.slot = 8'(slot);
                  break;
               end
               slot = (slot + 1 >= size) ? 0 : slot + 1;
               if (slot == first) break;
            end
         end
         ACT_FIND_VALUE: begin
            r.status = ST_NOT_FOUND;
            if (op.val != 0)
               for (int i = 0; i < size; i++)
                  if (mdl_values[i] == op.val) begin
                     r.status = ST_OK;
                     r.fname = mdl_names[i];
                     r.slot = 8'(i);
                     break;
                  end
         end
         default: begin
            for (int i = 0; i < DEPTH; i++) begin
               mdl_names[i] = '0;
               mdl_values[i] = '0;
            end
         end
      endcase
      return r;
   endfunction

   // names mostly drawn from a small pool so that duplicates and collisions are common
   function automatic logic [NAME_W-1:0] pick_name();
      logic [NAME_W-1:0] n;
      int len;
      case ($urandom_range(0, 3))
         0: n = {$urandom, $urandom};
         1: n = 64'($urandom_range(1, 12)) | 64'h6100;
         default: begin
            n = '0;
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) n[8*i +: 8] = 8'($urandom_range(1, 6) + 8'h40);
            // sometimes junk after the nul
            if (len < 8 && $urandom_range(0, 3) == 0) n[63:56] = 8'($urandom);
         end
      endcase
      return n;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return 32'($urandom_range(1, 20));
      endcase
   endfunction

   task automatic queue_op(action_type a, logic [NAME_W-1:0] n, logic [VALUE_W-1:0] v);
      pending_ops.push_back('{a, n, v});
   endtask

   // wait until every queued item has been sent and answered, then a margin
   // long enough for a full clear pass
   task automatic drain();
      while (pending_ops.size() != 0 || expected_resps.size() != 0 || busy || start)
         @(posedge clock);
      repeat (DEPTH + 20) @(posedge clock);
   endtask

   task automatic write_size(logic [SIZE_W-1:0] s);
      @(posedge clock);
      csr_wr_en      <= 1'b1;
      csr_table_size <= s;
      mdl_size        = s;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
   endtask

   // driver: bursts of items with random gaps in between
   int burst_left, gap_left;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         // the previous item (if any) was taken at this edge
         if (start) sent_count <= sent_count + 1;
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_ops.size() != 0 && !busy) begin
            table_op_t op;
            op = pending_ops.pop_front();
            expected_resps.push_back(apply_table_op(op));
            req_action    <= op.act;
            req_key_name  <= op.name;
            req_key_value <= op.val;
            start         <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 8);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: each strobe is matched to the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_resps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            table_resp_t e;
            e = expected_resps.pop_front();
            if (rsp_status !== e.status || rsp_found_value !== e.fval ||
                rsp_found_name !== e.fname || rsp_slot_index !== e.slot) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d val %h name %h slot %0d, got st %0d val %h name %h slot %0d",
                     e.status, e.fval, e.fname, e.slot,
                     rsp_status, rsp_found_value, rsp_found_name, rsp_slot_index);
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [NAME_W-1:0] stored_names[$];
      int sizes[6];
      mismatches = 0;
      sent_count = 0;
      idle_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      csr_wr_en = 1'b0;
      csr_table_size = 9'd256;
      req_action = ACT_INSERT;
      req_key_name = '0;
      req_key_value = '0;
      mdl_size = 9'd256;
      for (int i = 0; i < DEPTH; i++) begin
         mdl_names[i] = '0;
         mdl_values[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every action, duplicate, empty name, zero value
      queue_op(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(ACT_INSERT, 64'h0, 32'h1);
      queue_op(ACT_INSERT, 64'h00FF_0000_0000_4142, 32'h5);
      queue_op(ACT_INSERT, 64'h4142, 32'h6);
      queue_op(ACT_INSERT, 64'h4343, 32'h0);
      queue_op(ACT_FIND_NAME, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
      queue_op(ACT_FIND_NAME, 64'h0, 32'hFFFF_FFFF);
      queue_op(ACT_FIND_NAME, 64'h7777, 32'h0);
      queue_op(ACT_FIND_VALUE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5);
      queue_op(ACT_FIND_VALUE, 64'h0, 32'h0);
      queue_op(ACT_FIND_VALUE, 64'h0, 32'h1234);
      queue_op(ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      queue_op(ACT_FIND_VALUE, 64'h0, 32'h5);
      drain();

      // small table: fill it, then hit the full case and a wrapping miss
      write_size(9'd3);
      queue_op(ACT_INSERT, 64'h41, 32'h1);
      queue_op(ACT_INSERT, 64'h42, 32'h2);
      queue_op(ACT_INSERT, 64'h43, 32'h3);
      queue_op(ACT_INSERT, 64'h44, 32'h4);
      queue_op(ACT_FIND_NAME, 64'h45, 32'h0);
      queue_op(ACT_FIND_NAME, 64'h43, 32'h0);
      drain();
      // size zero acts as one; the slots above it stay untouched
      write_size(9'd0);
      queue_op(ACT_FIND_VALUE, 64'h0, 32'h2);
      queue_op(ACT_INSERT, 64'h46, 32'h9);
      drain();
      // oversize clamps to the full depth
      write_size(9'h1FF);
      queue_op(ACT_FIND_VALUE, 64'h0, 32'h3);
      queue_op(ACT_CLEAR, 64'h0, 32'h0);
      drain();

      // random phases across several sizes; clears are rare so tables fill up
      sizes = '{256, 1, 5, 17, 64, 256};
      foreach (sizes[p]) begin
         write_size(9'(sizes[p]));
         stored_names.delete();
         for (int k = 0; k < 90; k++) begin
            logic [NAME_W-1:0] nm;
            int pick;
            pick = $urandom_range(0, 99);
            nm = (stored_names.size() != 0 && $urandom_range(0, 1))
               ? stored_names[$urandom_range(0, stored_names.size() - 1)] : pick_name();
            if (pick < 40) begin
               queue_op(ACT_INSERT, nm, pick_value());
               stored_names.push_back(nm);
            end else if (pick < 70) queue_op(ACT_FIND_NAME, nm, pick_value());
            else if (pick < 97) queue_op(ACT_FIND_VALUE, pick_name(), pick_value());
            else queue_op(ACT_CLEAR, pick_name(), pick_value());
         end
         drain();
      end

      if (mismatches == 0 && expected_resps.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
